// ----- hw/rtl/prrs_pkg.sv -----
// Shared types and constants for the priority round-robin task manager.
// Used by the controller, the datapath, the top level and the port checker.
package prrs_pkg;

  localparam int KINDS  = 4;
  localparam int LEVELS = 3;

  // reset values of the four unit registers
  localparam logic [KINDS-1:0][3:0] UNITS_RST = {4'd4, 4'd3, 4'd2, 4'd1};

  typedef enum logic [1:0] {
    MODE_CREATE  = 2'd0,
    MODE_TIMEOUT = 2'd1,
    MODE_REQUEST = 2'd2,
    MODE_DESTROY = 2'd3
  } mode_e;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_BLOCKED = 2'd1;
  localparam logic [1:0] STATUS_REJECT  = 2'd2;

  typedef struct packed {
    mode_e      mode;
    logic [3:0] process_id;
    logic [1:0] prio_level;
    logic [1:0] resource_kind;
    logic [3:0] amount;
  } cmd_t;

  typedef struct packed {
    logic [3:0] running_task;
    logic       idle;
    logic [1:0] status;
    logic [3:0] woken_count;
  } res_t;

  // datapath operation for the current cycle
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_DISPATCH,
    OP_CREATE,
    OP_TO_RD,
    OP_TO_WR,
    OP_RQ_RD,
    OP_RQ_REC,
    OP_RQ_EXEC,
    OP_DS_REC,
    OP_DS_BRD,
    OP_DS_BCHK,
    OP_DS_QRD,
    OP_DS_QCHK,
    OP_DS_FREE,
    OP_SC_RD,
    OP_SC_REC,
    OP_SC_EXEC,
    OP_FIN_RD,
    OP_FIN_OUT
  } op_e;

  typedef struct packed {
    mode_e mode;
    logic  reject;
    logic  tgt_blocked;
    logic  more;
  } dp_stat_t;

endpackage

// ----- hw/rtl/prrs_ctrl.sv -----
// Sequencer for the task manager: one state per datapath operation.
// Depends on prrs_pkg for the operation codes and the datapath status.
module prrs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  prrs_pkg::dp_stat_t stat_i,
  output prrs_pkg::op_e      op_o,
  output logic               latch_o,
  output logic               busy_o,
  output logic               res_valid_o
);
  import prrs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_CREATE, S_TO_RD, S_TO_WR, S_RQ_RD, S_RQ_REC, S_RQ_EXEC,
    S_DS_REC, S_DS_BRD, S_DS_BCHK, S_DS_QRD, S_DS_QCHK, S_DS_FREE,
    S_SC_RD, S_SC_REC, S_SC_EXEC, S_FIN_RD, S_FIN_OUT
  } state_e;

  state_e state_q, state_d;
  op_e    op_q;
  logic   busy_q, res_valid_q;

  function automatic op_e op_of(input state_e s);
    op_e o;
    case (s)
      S_IDLE:     o = OP_IDLE;
      S_DISPATCH: o = OP_DISPATCH;
      S_CREATE:   o = OP_CREATE;
      S_TO_RD:    o = OP_TO_RD;
      S_TO_WR:    o = OP_TO_WR;
      S_RQ_RD:    o = OP_RQ_RD;
      S_RQ_REC:   o = OP_RQ_REC;
      S_RQ_EXEC:  o = OP_RQ_EXEC;
      S_DS_REC:   o = OP_DS_REC;
      S_DS_BRD:   o = OP_DS_BRD;
      S_DS_BCHK:  o = OP_DS_BCHK;
      S_DS_QRD:   o = OP_DS_QRD;
      S_DS_QCHK:  o = OP_DS_QCHK;
      S_DS_FREE:  o = OP_DS_FREE;
      S_SC_RD:    o = OP_SC_RD;
      S_SC_REC:   o = OP_SC_REC;
      S_SC_EXEC:  o = OP_SC_EXEC;
      S_FIN_RD:   o = OP_FIN_RD;
      S_FIN_OUT:  o = OP_FIN_OUT;
      default:    o = OP_IDLE;
    endcase
    return o;
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (start) state_d = S_DISPATCH;
      S_DISPATCH: begin
        if (stat_i.reject) begin
          state_d = S_FIN_RD;
        end else begin
          case (stat_i.mode)
            MODE_CREATE:  state_d = S_CREATE;
            MODE_TIMEOUT: state_d = S_TO_RD;
            MODE_REQUEST: state_d = S_RQ_RD;
            default:      state_d = S_DS_REC;
          endcase
        end
      end
      S_CREATE:   state_d = S_FIN_RD;
      S_TO_RD:    state_d = S_TO_WR;
      S_TO_WR:    state_d = S_FIN_RD;
      S_RQ_RD:    state_d = S_RQ_REC;
      S_RQ_REC:   state_d = S_RQ_EXEC;
      S_RQ_EXEC:  state_d = S_FIN_RD;
      S_DS_REC:   state_d = stat_i.tgt_blocked ? S_DS_BRD : S_DS_QRD;
      S_DS_BRD:   state_d = stat_i.more ? S_DS_BCHK : S_DS_FREE;
      S_DS_BCHK:  state_d = S_DS_BRD;
      S_DS_QRD:   state_d = stat_i.more ? S_DS_QCHK : S_DS_FREE;
      S_DS_QCHK:  state_d = S_DS_QRD;
      S_DS_FREE:  state_d = S_SC_RD;
      S_SC_RD:    state_d = stat_i.more ? S_SC_REC : S_FIN_RD;
      S_SC_REC:   state_d = S_SC_EXEC;
      S_SC_EXEC:  state_d = S_SC_RD;
      S_FIN_RD:   state_d = S_FIN_OUT;
      S_FIN_OUT:  state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_IDLE;
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_of(state_d);
      busy_q      <= (state_d != S_IDLE);
      res_valid_q <= (state_d == S_FIN_OUT);
    end
  end

  assign op_o        = op_q;
  assign latch_o     = (state_q == S_IDLE) && start;
  assign busy_o      = busy_q;
  assign res_valid_o = res_valid_q;

endmodule

// ----- hw/rtl/prrs_dpath.sv -----
// Datapath of the task manager: ready queue, blocked list and task record
// memories, queue pointers and unit counters. Depends on prrs_pkg.
module prrs_dpath #(
  parameter int TASKS    = 16,
  parameter int UNIT_MAX = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prrs_pkg::cmd_t     cmd_i,
  input  logic               latch_i,
  input  prrs_pkg::op_e      op_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [3:0]         cfg_data_i,
  output prrs_pkg::dp_stat_t stat_o,
  output prrs_pkg::res_t     res_o
);
  import prrs_pkg::*;

  localparam int TW  = $clog2(TASKS);
  localparam int CW  = $clog2(TASKS + 1);
  localparam int QD  = LEVELS * TASKS;
  localparam int QAW = $clog2(QD);
  localparam int UW  = $clog2(UNIT_MAX + 1);
  localparam int AW  = (UW > 4) ? UW : 4;

  typedef struct packed {
    logic [1:0]                prio;
    logic [1:0]                wkind;
    logic [3:0]                wunits;
    logic [KINDS-1:0][UW-1:0]  held;
  } rec_t;

  // storage
  logic [TW-1:0] rq_mem [QD];
  logic [TW-1:0] bl_mem [TASKS];
  rec_t          rec_mem [TASKS];

  logic [TW-1:0] rq_rd_q, bl_rd_q;
  logic          rq_zero_q, rec_zero_q;
  rec_t          rec_rd_q;
  logic          slot0_ok_q;

  cmd_t                       cmd_q;
  logic [TASKS-1:0]           valid_q, blk_q, rv_q;
  logic [LEVELS-1:0][TW-1:0]  heads_q;
  logic [LEVELS-1:0][CW-1:0]  counts_q;
  logic [KINDS-1:0][UW-1:0]   avail_q;
  logic [CW-1:0]              total_q, idx_q, kept_q;
  logic [TW-1:0]              tgt_q;
  logic                       found_q;
  logic [3:0]                 woken_q;
  logic [1:0]                 status_q;

  function automatic logic [QAW-1:0] qaddr(input logic [1:0] lv, input logic [TW-1:0] head,
                                           input logic [CW-1:0] p);
    logic [CW:0] pos;
    pos = (CW+1)'(head) + (CW+1)'(p);
    if (pos >= (CW+1)'(TASKS)) pos = pos - (CW+1)'(TASKS);
    return QAW'(32'(lv) * TASKS + 32'(pos));
  endfunction

  function automatic logic [UW-1:0] sat(input logic [UW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = (AW+1)'(a) + (AW+1)'(b);
    return (s > (AW+1)'(UNIT_MAX)) ? UW'(UNIT_MAX) : UW'(s);
  endfunction

  function automatic logic [UW-1:0] clamp(input logic [3:0] v);
    return (32'(v) > UNIT_MAX) ? UW'(UNIT_MAX) : UW'(v);
  endfunction

  function automatic logic [1:0] lvl(input logic [1:0] p);
    return (32'(p) < LEVELS) ? p : 2'd0;
  endfunction

  function automatic logic [TW-1:0] inc_head(input logic [TW-1:0] h);
    return (32'(h) == TASKS - 1) ? '0 : h + TW'(1);
  endfunction

  // derived values
  logic [TW-1:0]  rq_data, bl_data, idt;
  rec_t           rec_data;
  logic           top_any, id_in, fits, more;
  logic [1:0]     top_lv, cprio, rlv;
  logic [1:0]     kind;

  assign rq_data  = rq_zero_q ? '0 : rq_rd_q;
  assign bl_data  = bl_rd_q;
  assign rec_data = rec_zero_q ? '0 : rec_rd_q;
  assign idt      = TW'(cmd_q.process_id);
  assign id_in    = 32'(cmd_q.process_id) < TASKS;
  assign cprio    = lvl(cmd_q.prio_level);
  assign rlv      = lvl(rec_data.prio);
  assign kind     = cmd_q.resource_kind;
  assign top_any  = (counts_q[0] != '0) || (counts_q[1] != '0) || (counts_q[2] != '0);

  always_comb begin
    if (counts_q[2] != '0)      top_lv = 2'd2;
    else if (counts_q[1] != '0) top_lv = 2'd1;
    else                        top_lv = 2'd0;
  end

  // memory port controls
  logic             rq_we, rq_re, bl_we, bl_re, rec_we, rec_re;
  logic [QAW-1:0]   rq_waddr, rq_raddr;
  logic [TW-1:0]    rq_wdata, bl_waddr, bl_wdata, rec_waddr, rec_raddr;
  rec_t             rec_wdata;

  always_comb begin
    rq_we     = 1'b0;
    rq_re     = 1'b0;
    rq_waddr  = qaddr(top_lv, heads_q[top_lv], counts_q[top_lv]);
    rq_raddr  = qaddr(top_lv, heads_q[top_lv], '0);
    rq_wdata  = rq_data;
    bl_we     = 1'b0;
    bl_re     = 1'b0;
    bl_waddr  = kept_q[TW-1:0];
    bl_wdata  = tgt_q;
    rec_we    = 1'b0;
    rec_re    = 1'b0;
    rec_waddr = tgt_q;
    rec_raddr = tgt_q;
    rec_wdata = rec_data;
    fits      = 1'b0;
    more      = 1'b0;
    case (op_i)
      OP_CREATE: begin
        rq_we     = counts_q[cprio] < CW'(TASKS);
        rq_waddr  = qaddr(cprio, heads_q[cprio], counts_q[cprio]);
        rq_wdata  = idt;
        rec_we    = 1'b1;
        rec_waddr = idt;
        rec_wdata = '0;
        rec_wdata.prio = cprio;
      end
      OP_TO_RD, OP_RQ_RD, OP_FIN_RD: rq_re = 1'b1;
      OP_TO_WR: rq_we = 1'b1;
      OP_RQ_REC: begin
        rec_re    = 1'b1;
        rec_raddr = rq_data;
      end
      OP_RQ_EXEC: begin
        fits   = AW'(avail_q[kind]) >= AW'(cmd_q.amount);
        rec_we = 1'b1;
        if (fits) begin
          rec_wdata.held[kind] = sat(rec_data.held[kind], AW'(cmd_q.amount));
        end else begin
          rec_wdata.wkind  = kind;
          rec_wdata.wunits = cmd_q.amount;
          bl_we            = total_q < CW'(TASKS);
          bl_waddr         = total_q[TW-1:0];
        end
      end
      OP_DS_REC: rec_re = 1'b1;
      OP_DS_BRD, OP_SC_RD: begin
        more  = idx_q < total_q;
        bl_re = more;
      end
      OP_DS_BCHK: begin
        bl_we    = bl_data != tgt_q;
        bl_wdata = bl_data;
      end
      OP_DS_QRD: begin
        // after the hit, each step moves slot p+1 down to slot p
        more     = found_q ? ((CW+1)'(idx_q) + (CW+1)'(1) < (CW+1)'(counts_q[rlv]))
                           : (idx_q < counts_q[rlv]);
        rq_re    = more;
        rq_raddr = qaddr(rlv, heads_q[rlv], found_q ? idx_q + CW'(1) : idx_q);
      end
      OP_DS_QCHK: begin
        rq_we    = found_q;
        rq_waddr = qaddr(rlv, heads_q[rlv], idx_q);
      end
      OP_SC_REC: begin
        rec_re    = 1'b1;
        rec_raddr = bl_data;
      end
      OP_SC_EXEC: begin
        fits = AW'(rec_data.wunits) <= AW'(avail_q[rec_data.wkind]);
        if (fits) begin
          rec_we = 1'b1;
          rec_wdata.held[rec_data.wkind] = sat(rec_data.held[rec_data.wkind],
                                               AW'(rec_data.wunits));
          rec_wdata.wkind  = '0;
          rec_wdata.wunits = '0;
          rq_we    = counts_q[rlv] < CW'(TASKS);
          rq_waddr = qaddr(rlv, heads_q[rlv], counts_q[rlv]);
          rq_wdata = tgt_q;
        end else begin
          bl_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (rq_we) rq_mem[rq_waddr] <= rq_wdata;
    if (rq_re) begin
      rq_rd_q   <= rq_mem[rq_raddr];
      rq_zero_q <= (rq_raddr == '0) && !slot0_ok_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bl_we) bl_mem[bl_waddr] <= bl_wdata;
    if (bl_re) bl_rd_q <= bl_mem[idx_q[TW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    if (rec_re) begin
      rec_rd_q   <= rec_mem[rec_raddr];
      rec_zero_q <= !rv_q[rec_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (latch_i) cmd_q <= cmd_i;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= TASKS'(1);
      blk_q      <= '0;
      rv_q       <= '0;
      heads_q    <= '0;
      // queue 0 holds the init task
      counts_q   <= (LEVELS*CW)'(1);
      total_q    <= '0;
      for (int k = 0; k < KINDS; k++) avail_q[k] <= clamp(UNITS_RST[k]);
      slot0_ok_q <= 1'b0;
      tgt_q      <= '0;
      idx_q      <= '0;
      kept_q     <= '0;
      found_q    <= 1'b0;
      woken_q    <= '0;
      status_q   <= STATUS_DONE;
    end else begin
      if (cfg_we_i) avail_q[cfg_index_i] <= clamp(cfg_data_i);
      if (rq_we && rq_waddr == '0) slot0_ok_q <= 1'b1;
      if (rec_we) rv_q[rec_waddr] <= 1'b1;
      if (latch_i) begin
        status_q <= STATUS_DONE;
        woken_q  <= '0;
        idx_q    <= '0;
        kept_q   <= '0;
        found_q  <= 1'b0;
      end
      case (op_i)
        OP_DISPATCH: begin
          tgt_q <= idt;
          if (stat_o.reject) status_q <= STATUS_REJECT;
        end
        OP_CREATE: begin
          valid_q[idt] <= 1'b1;
          blk_q[idt]   <= 1'b0;
          if (counts_q[cprio] < CW'(TASKS)) counts_q[cprio] <= counts_q[cprio] + CW'(1);
        end
        OP_TO_WR: heads_q[top_lv] <= inc_head(heads_q[top_lv]);
        OP_RQ_REC: tgt_q <= rq_data;
        OP_RQ_EXEC: begin
          if (fits) begin
            avail_q[kind] <= avail_q[kind] - UW'(cmd_q.amount);
          end else begin
            // the requester is the head, so dropping it just advances the head
            heads_q[top_lv]  <= inc_head(heads_q[top_lv]);
            counts_q[top_lv] <= counts_q[top_lv] - CW'(1);
            blk_q[tgt_q]     <= 1'b1;
            if (total_q < CW'(TASKS)) total_q <= total_q + CW'(1);
            status_q <= STATUS_BLOCKED;
          end
        end
        OP_DS_BRD: if (!more) total_q <= kept_q;
        OP_DS_BCHK: begin
          if (bl_data != tgt_q) kept_q <= kept_q + CW'(1);
          idx_q <= idx_q + CW'(1);
        end
        OP_DS_QRD: if (!more && found_q) counts_q[rlv] <= counts_q[rlv] - CW'(1);
        OP_DS_QCHK: begin
          if (found_q) idx_q <= idx_q + CW'(1);
          else if (rq_data == tgt_q) found_q <= 1'b1;
          else idx_q <= idx_q + CW'(1);
        end
        OP_DS_FREE: begin
          for (int k = 0; k < KINDS; k++) avail_q[k] <= sat(avail_q[k], AW'(rec_data.held[k]));
          rv_q[tgt_q]    <= 1'b0;
          valid_q[tgt_q] <= 1'b0;
          blk_q[tgt_q]   <= 1'b0;
          idx_q          <= '0;
          kept_q         <= '0;
        end
        OP_SC_RD: if (!more) total_q <= kept_q;
        OP_SC_REC: tgt_q <= bl_data;
        OP_SC_EXEC: begin
          idx_q <= idx_q + CW'(1);
          if (fits) begin
            avail_q[rec_data.wkind] <= avail_q[rec_data.wkind] - UW'(rec_data.wunits);
            blk_q[tgt_q] <= 1'b0;
            if (counts_q[rlv] < CW'(TASKS)) counts_q[rlv] <= counts_q[rlv] + CW'(1);
            if (woken_q != 4'hF) woken_q <= woken_q + 4'd1;
          end else begin
            kept_q <= kept_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // status back to the sequencer
  always_comb begin
    stat_o.mode        = cmd_q.mode;
    stat_o.tgt_blocked = blk_q[tgt_q];
    stat_o.more        = more;
    case (cmd_q.mode)
      MODE_CREATE:  stat_o.reject = !(id_in && !valid_q[idt] && 32'(cmd_q.prio_level) < LEVELS);
      MODE_TIMEOUT: stat_o.reject = !top_any;
      MODE_REQUEST: stat_o.reject = !top_any;
      default:      stat_o.reject = !(id_in && valid_q[idt]);
    endcase
  end

  assign res_o.running_task = top_any ? 4'(rq_data) : 4'd0;
  assign res_o.idle         = !top_any;
  assign res_o.status       = status_q;
  assign res_o.woken_count  = woken_q;

endmodule

// ----- hw/rtl/priority_rr_scheduler_with_resources.sv -----
// Task manager with three priority ready queues and four resource kinds.
// Top level: instantiates prrs_ctrl and prrs_dpath; uses prrs_pkg.
//
// Usage:
//   Command channel: cmd_i is taken at a rising edge with start high and busy
//   low. busy stays high until the result has been shown.
//   Result channel: res_o is valid for exactly one cycle with res_valid_o;
//   the receiver cannot stall it. One result per command.
//   Config channel: cfg_index_i / cfg_data_i are written when cfg_valid_i and
//   cfg_ready_o are high; ready is high whenever the block is not busy. A
//   write loads the available count of that kind, clipped to UNIT_MAX.
// Sequence per command: a rejected command goes straight to the result read;
//   create writes the queue and task record; timeout reads the head and
//   requeues it; request reads the head, its record, then grants or blocks;
//   destroy searches the blocked list or the target's ready queue, frees its
//   units and scans the blocked list to wake tasks whose wait now fits.
// A new command is taken in the cycle after the result.
// Reset: task 0 ready at priority 0, blocked list empty, counts from reset.
module priority_rr_scheduler_with_resources #(
  parameter int TASKS    = 16,
  parameter int UNIT_MAX = 15
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  prrs_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  output prrs_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [3:0]     cfg_data_i
);
  import prrs_pkg::*;

  op_e      op;
  logic     latch;
  dp_stat_t stat;

  assign cfg_ready_o = !busy;

  prrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .stat_i      (stat),
    .op_o        (op),
    .latch_o     (latch),
    .busy_o      (busy),
    .res_valid_o (res_valid_o)
  );

  prrs_dpath #(
    .TASKS    (TASKS),
    .UNIT_MAX (UNIT_MAX)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .latch_i     (latch),
    .op_i        (op),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (stat),
    .res_o       (res_o)
  );

endmodule

// ----- hw/rtl/prrs_chk.sv -----
// Port-level checks for the task manager, bound to the top level.
// Depends on prrs_pkg for the result type and status codes.
module prrs_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           res_valid_o,
  input prrs_pkg::res_t res_o
);
  import prrs_pkg::*;

  a_res_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result outside a busy window");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !busy && !res_valid_o) else $error("result not followed by idle");

  a_take_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted command did not raise busy");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.idle |-> res_o.running_task == 4'd0)
    else $error("idle result names a task");

  a_woken_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != STATUS_DONE |-> res_o.woken_count == 4'd0)
    else $error("wakeups on a failed command");

endmodule

bind priority_rr_scheduler_with_resources prrs_chk u_prrs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
